@@ rtl/core/dfs_pkg.sv @@
// shared types and character codes for the delimited field splitter
package dfs_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0a;
  localparam char_t CH_CR    = 8'h0d;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_COMMA = 8'h2c;
  localparam char_t CH_SEMI  = 8'h3b;

  // separator after reset: tab
  localparam char_t SEP_RESET = CH_TAB;

endpackage

@@ rtl/core/dfs_channels.sv @@
// request channel interfaces of the delimited field splitter
interface dfs_in_if;
  import dfs_pkg::*;
  logic  valid;
  logic  ready;
  char_t text_byte;
  logic  end_of_input;
  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface dfs_out_if;
  import dfs_pkg::*;
  logic  valid;
  logic  ready;
  char_t field_byte;
  logic  byte_valid;
  logic  field_end;
  logic  record_end;
  modport source (output valid, output field_byte, output byte_valid, output field_end,
                  output record_end, input ready);
  modport sink (input valid, input field_byte, input byte_valid, input field_end,
                input record_end, output ready);
endinterface

interface dfs_cfg_if;
  import dfs_pkg::*;
  logic  valid;
  logic  ready;
  char_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/delimited_field_splitter_top.sv @@
// top level of the delimited field splitter
//
// usage
//   in_chan  : one text byte per request, with end_of_input (byte then taken as zero)
//   out_chan : one result request per input byte that yields something: field_byte
//              with byte_valid, field_end and record_end flags; bytes that yield
//              nothing (skipped blanks, carriage returns, end at line start) give none
//   cfg_chan : writes field_separator, always ready; the value is latched at each
//              line start, so a write takes effect on the next line
// an accepted byte passes the input register, then the result register, before result valid
// throughput: 1 byte per cycle while the receiver takes results, set by the combinational
//   state update between the input register and the result register
// a stalled receiver holds the result register; one more byte is taken into the
//   input register, then in_chan.ready drops until the result is taken
// reset (rst_n low, synchronous) empties both registers, sets the separator to tab
//   and puts the parser at line start
module delimited_field_splitter_top (
  input  logic      clk,
  input  logic      rst_n,
  dfs_in_if.sink    in_chan,
  dfs_out_if.source out_chan,
  dfs_cfg_if.sink   cfg_chan
);
  import dfs_pkg::*;

  // parser phase kept between bytes
  typedef enum logic [1:0] {
    PH_LINE,
    PH_SEP,
    PH_SEPCR,
    PH_TOKEN
  } phase_t;

  // steps walked within one byte
  typedef enum logic [1:0] {
    W_SEP,
    W_CHECK,
    W_TOKEN
  } walk_t;

  // upper bound on the walk through the step graph for one byte
  localparam int WALK_STEPS = 6;

  // configuration
  char_t  field_sep_r;

  // parser state
  phase_t phase_r, phase_nxt;
  logic   fixed_r, fixed_nxt;
  logic   sep_taken_r, sep_taken_nxt;
  logic   line_first_r, line_first_nxt;
  char_t  line_sep_r, line_sep_nxt;

  // input register
  logic   in_valid_r;
  char_t  in_char_r;

  // result register
  logic   out_valid_r, out_valid_nxt;
  char_t  out_byte_r, out_byte_nxt;
  logic   out_bv_r, out_bv_nxt;
  logic   out_fe_r, out_fe_nxt;
  logic   out_re_r, out_re_nxt;

  logic   advance;
  logic   has_result;
  char_t  c_in;

  // held item moves on when the result register is free or being emptied
  assign advance      = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  // end of input reads as a zero byte
  assign c_in = in_chan.end_of_input ? CH_NUL : in_chan.text_byte;

  // one byte through the parser
  always_comb begin
    char_t  c;
    walk_t  w;
    logic   done;
    logic   gap;
    logic   consumes;
    logic   continues;
    c              = in_char_r;
    phase_nxt      = phase_r;
    fixed_nxt      = fixed_r;
    sep_taken_nxt  = sep_taken_r;
    line_first_nxt = line_first_r;
    line_sep_nxt   = line_sep_r;
    out_byte_nxt   = CH_NUL;
    out_bv_nxt     = 1'b0;
    out_fe_nxt     = 1'b0;
    out_re_nxt     = 1'b0;
    done           = 1'b0;
    w              = W_SEP;
    gap            = (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_TAB);

    // line start latches the separator and picks the mode from the first byte
    unique case (phase_r)
      PH_LINE: begin
        line_first_nxt = 1'b1;
        sep_taken_nxt  = 1'b1;
        line_sep_nxt   = field_sep_r;
        fixed_nxt      = (c != CH_SPACE) && (field_sep_r != CH_NUL);
        w              = W_SEP;
      end
      PH_SEP:   w = W_SEP;
      PH_SEPCR: w = W_CHECK;
      PH_TOKEN: w = W_TOKEN;
      default:  w = W_SEP;
    endcase

    for (int i = 0; i < WALK_STEPS; i++) begin
      consumes  = fixed_nxt ? (!sep_taken_nxt && (c == line_sep_nxt))
                            : ((c == CH_SPACE) || (!sep_taken_nxt && gap));
      continues = (c != CH_NUL) && (c != CH_LF) && (c != CH_CR) &&
                  (fixed_nxt ? (c != line_sep_nxt) : ((c != CH_SPACE) && !gap));
      if (!done) begin
        unique case (w)
          W_SEP: begin
            if (consumes) begin
              if (c != CH_SPACE) sep_taken_nxt = 1'b1;
              phase_nxt = PH_SEP;
              done      = 1'b1;
            end else if (c == CH_CR) begin
              phase_nxt = PH_SEPCR;
              done      = 1'b1;
            end else begin
              w = W_CHECK;
            end
          end
          W_CHECK: begin
            // end of line or input closes the record unless still before the first field
            if (((c == CH_NUL) && (line_first_nxt || !sep_taken_nxt)) ||
                ((c == CH_LF) && !sep_taken_nxt)) begin
              if (!line_first_nxt) out_re_nxt = 1'b1;
              phase_nxt = PH_LINE;
              done      = 1'b1;
            end else begin
              line_first_nxt = 1'b0;
              w              = W_TOKEN;
            end
          end
          default: begin
            if (continues) begin
              out_byte_nxt = c;
              out_bv_nxt   = 1'b1;
              phase_nxt    = PH_TOKEN;
              done         = 1'b1;
            end else begin
              // field closes, the byte is looked at again as a separator
              out_fe_nxt     = 1'b1;
              line_first_nxt = 1'b0;
              sep_taken_nxt  = 1'b0;
              w              = W_SEP;
            end
          end
        endcase
      end
    end
  end

  assign has_result = out_bv_nxt || out_fe_nxt || out_re_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || out_chan.ready) out_valid_nxt = advance && has_result;
  end

  // control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_sep_r  <= SEP_RESET;
      phase_r      <= PH_LINE;
      fixed_r      <= 1'b0;
      sep_taken_r  <= 1'b0;
      line_first_r <= 1'b1;
      line_sep_r   <= CH_NUL;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid) field_sep_r <= cfg_chan.data;
      if (in_chan.ready) in_valid_r <= in_chan.valid;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r      <= phase_nxt;
        fixed_r      <= fixed_nxt;
        sep_taken_r  <= sep_taken_nxt;
        line_first_r <= line_first_nxt;
        line_sep_r   <= line_sep_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) in_char_r <= c_in;
    if (advance && has_result) begin
      out_byte_r <= out_byte_nxt;
      out_bv_r   <= out_bv_nxt;
      out_fe_r   <= out_fe_nxt;
      out_re_r   <= out_re_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.field_byte = out_byte_r;
  assign out_chan.byte_valid = out_bv_r;
  assign out_chan.field_end  = out_fe_r;
  assign out_chan.record_end = out_re_r;

`ifndef SYNTHESIS
  // parser state only moves when the held byte is processed
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> ($stable(phase_r) && $stable(sep_taken_r)))
    else $error("parser state changed while byte was held");

  // a field byte never closes the record in the same result
  a_byte_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bv_r) |-> !out_re_r)
    else $error("byte_valid together with record_end");

  // input only backs up when both registers are full
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (in_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled with free register");
`endif

endmodule

@@ test/testbench.sv @@
// self-checking testbench of the delimited field splitter: directed table, then random lines
`timescale 1ns / 1ps

module testbench;
  import dfs_pkg::*;

  // one result request as the block emits it
  typedef struct packed {
    char_t field_byte;
    logic  byte_valid;
    logic  field_end;
    logic  record_end;
  } split_result_t;

  // scanner phases of the field predictor
  typedef enum logic [2:0] {
    SCAN_LINE_START,
    SCAN_SEPARATOR,
    SCAN_AFTER_CR,
    SCAN_FIELD,
    SCAN_CHECK
  } scan_state_t;

  // how a stimulus row is checked, or a separator write
  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_NO_RESULT,
    ROW_GIVEN,
    ROW_SEPARATOR
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    char_t         text;
    logic          eoi;
    split_result_t given;
  } stim_row_t;

  logic clk;
  logic rst_n;

  dfs_in_if  in_chan ();
  dfs_out_if out_chan ();
  dfs_cfg_if cfg_chan ();

  delimited_field_splitter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predictor state, mirrors the block's scanner
  char_t       sep_cfg;
  char_t       line_sep;
  scan_state_t scan_phase;
  bit          fixed_line;
  bit          sep_consumed;
  bit          before_first_field;

  split_result_t expected_fields_q[$];
  stim_row_t     dir_rows[$];
  int            fail_count;
  int            accepted_bytes;
  bit            steady;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop far beyond the slowest legal run
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic split_result_t res_of(char_t fb, bit bv, bit fe, bit re);
    split_result_t r;
    r.field_byte = fb;
    r.byte_valid = bv;
    r.field_end  = fe;
    r.record_end = re;
    return r;
  endfunction

  // comma, semicolon and tab may sit once in a blank gap
  function automatic bit is_gap_punct(char_t c);
    return c == CH_COMMA || c == CH_SEMI || c == CH_TAB;
  endfunction

  // gap between fields swallows this byte
  function automatic bit gap_takes(char_t c);
    if (fixed_line)
      return !sep_consumed && c == line_sep;
    return c == CH_SPACE || (!sep_consumed && is_gap_punct(c));
  endfunction

  // byte extends the current field
  function automatic bit field_goes_on(char_t c);
    if (c == CH_NUL || c == CH_LF || c == CH_CR)
      return 1'b0;
    if (fixed_line)
      return c != line_sep;
    return c != CH_SPACE && !is_gap_punct(c);
  endfunction

  // advance the predictor by one byte, report the result it causes if any
  task automatic predict_split(input char_t raw, input logic eoi,
                               output bit produced, output split_result_t res);
    char_t       c;
    scan_state_t st;
    bit          done;
    c = eoi ? CH_NUL : raw;
    res = '0;
    st = scan_phase;
    done = 1'b0;
    // first byte of a line picks fixed or blank mode and latches the separator
    if (st == SCAN_LINE_START) begin
      before_first_field = 1'b1;
      sep_consumed = 1'b1;
      line_sep = sep_cfg;
      fixed_line = (c != CH_SPACE && line_sep != CH_NUL);
      st = SCAN_SEPARATOR;
    end
    while (!done) begin
      case (st) inside
        SCAN_SEPARATOR: begin
          if (gap_takes(c)) begin
            if (c != CH_SPACE)
              sep_consumed = 1'b1;
            scan_phase = SCAN_SEPARATOR;
            done = 1'b1;
          end else if (c == CH_CR) begin
            scan_phase = SCAN_AFTER_CR;
            done = 1'b1;
          end else begin
            st = SCAN_CHECK;
          end
        end
        SCAN_AFTER_CR, SCAN_CHECK: begin
          // end of line or end of input closes the record
          if ((c == CH_NUL && (before_first_field || !sep_consumed)) ||
              (c == CH_LF && !sep_consumed)) begin
            if (!before_first_field)
              res.record_end = 1'b1;
            scan_phase = SCAN_LINE_START;
            done = 1'b1;
          end else begin
            before_first_field = 1'b0;
            st = SCAN_FIELD;
          end
        end
        default: begin
          if (field_goes_on(c)) begin
            res.field_byte = c;
            res.byte_valid = 1'b1;
            scan_phase = SCAN_FIELD;
            done = 1'b1;
          end else begin
            // field closes, the byte goes on to the gap scan
            res.field_end = 1'b1;
            before_first_field = 1'b0;
            sep_consumed = 1'b0;
            st = SCAN_SEPARATOR;
          end
        end
      endcase
    end
    produced = res.byte_valid | res.field_end | res.record_end;
  endtask

  // send one text byte request, record what it should give once it is taken
  task automatic push_text(input char_t b, input logic eoi, input row_kind_t kind,
                           input split_result_t given);
    bit            produced;
    split_result_t res;
    // random gaps on the sender side
    while (!steady && $urandom_range(99) < 18) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.text_byte    <= b;
    in_chan.end_of_input <= eoi;
    @(posedge clk);
    while (!in_chan.ready)
      @(posedge clk);
    accepted_bytes++;
    predict_split(b, eoi, produced, res);
    // typed rows override the predictor, which still tracks the state
    if (kind == ROW_GIVEN)
      expected_fields_q.push_back(given);
    else if (kind == ROW_PREDICTED && produced)
      expected_fields_q.push_back(res);
  endtask

  // separator write, only with the block drained
  task automatic write_separator(input char_t v);
    in_chan.valid <= 1'b0;
    while (expected_fields_q.size() != 0)
      @(posedge clk);
    // a byte that gives no result may still be in flight
    repeat (4) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    @(posedge clk);
    while (!cfg_chan.ready)
      @(posedge clk);
    sep_cfg = v;
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input char_t text, input logic eoi,
                         input split_result_t given);
    stim_row_t r;
    r.kind  = kind;
    r.text  = text;
    r.eoi   = eoi;
    r.given = given;
    dir_rows.push_back(r);
  endtask

  // mostly printable field content, sometimes any byte
  function automatic char_t field_char();
    if ($urandom_range(99) < 85)
      return char_t'($urandom_range(8'h21, 8'h7e));
    return char_t'($urandom_range(255));
  endfunction

  // one line of random fields with a random gap style and line end
  task automatic send_line();
    int    n_fields;
    int    len;
    int    pick;
    char_t gap_char;
    n_fields = $urandom_range(0, 4);
    // leading blanks switch the line to blank mode
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 2)) push_text(CH_SPACE, 1'b0, ROW_PREDICTED, '0);
    for (int k = 0; k < n_fields; k++) begin
      len = $urandom_range(0, 4);
      for (int j = 0; j < len; j++)
        push_text(field_char(), 1'b0, ROW_PREDICTED, '0);
      if (k < n_fields - 1) begin
        pick = $urandom_range(99);
        case ($urandom_range(2))
          0:       gap_char = CH_COMMA;
          1:       gap_char = CH_SEMI;
          default: gap_char = CH_TAB;
        endcase
        if (pick < 40) begin
          push_text(sep_cfg, 1'b0, ROW_PREDICTED, '0);
        end else if (pick < 55) begin
          // doubled separator, an empty field in fixed mode
          push_text(sep_cfg, 1'b0, ROW_PREDICTED, '0);
          push_text(sep_cfg, 1'b0, ROW_PREDICTED, '0);
        end else if (pick < 75) begin
          repeat ($urandom_range(1, 3)) push_text(CH_SPACE, 1'b0, ROW_PREDICTED, '0);
        end else if (pick < 88) begin
          push_text(gap_char, 1'b0, ROW_PREDICTED, '0);
        end else begin
          // blank gap with one punctuation byte inside
          push_text(CH_SPACE, 1'b0, ROW_PREDICTED, '0);
          push_text(gap_char, 1'b0, ROW_PREDICTED, '0);
          push_text(CH_SPACE, 1'b0, ROW_PREDICTED, '0);
        end
      end
    end
    // line end
    pick = $urandom_range(99);
    if (pick < 50) begin
      push_text(CH_LF, 1'b0, ROW_PREDICTED, '0);
    end else if (pick < 70) begin
      push_text(CH_CR, 1'b0, ROW_PREDICTED, '0);
      push_text(CH_LF, 1'b0, ROW_PREDICTED, '0);
    end else if (pick < 80) begin
      push_text(CH_NUL, 1'b0, ROW_PREDICTED, '0);
    end else if (pick < 90) begin
      push_text(char_t'($urandom_range(255)), 1'b1, ROW_PREDICTED, '0);
    end else begin
      // lone carriage return followed by more field text
      push_text(CH_CR, 1'b0, ROW_PREDICTED, '0);
      push_text(field_char(), 1'b0, ROW_PREDICTED, '0);
      push_text(CH_LF, 1'b0, ROW_PREDICTED, '0);
    end
    // noise between lines
    if ($urandom_range(99) < 12)
      repeat ($urandom_range(1, 5))
        push_text(char_t'($urandom_range(255)), $urandom_range(99) < 10,
                  ROW_PREDICTED, '0);
  endtask

  // result side: random stalls, compare each taken result with the oldest expectation
  initial begin
    split_result_t want;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_fields_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h valid %b end %b record %b", $time,
                   out_chan.field_byte, out_chan.byte_valid, out_chan.field_end,
                   out_chan.record_end);
          fail_count++;
        end else begin
          want = expected_fields_q.pop_front();
          if (out_chan.field_byte !== want.field_byte) begin
            $display("%0t: field_byte expected %02h actual %02h", $time,
                     want.field_byte, out_chan.field_byte);
            fail_count++;
          end
          if (out_chan.byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %b actual %b", $time,
                     want.byte_valid, out_chan.byte_valid);
            fail_count++;
          end
          if (out_chan.field_end !== want.field_end) begin
            $display("%0t: field_end expected %b actual %b", $time,
                     want.field_end, out_chan.field_end);
            fail_count++;
          end
          if (out_chan.record_end !== want.record_end) begin
            $display("%0t: record_end expected %b actual %b", $time,
                     want.record_end, out_chan.record_end);
            fail_count++;
          end
        end
      end
      out_chan.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  // main sequence
  initial begin
    char_t seps[6];
    char_t sep_pick;
    int    phase_start;
    fail_count     = 0;
    accepted_bytes = 0;
    steady         = 1'b0;
    // predictor after reset: line start, tab separator
    sep_cfg            = SEP_RESET;
    line_sep           = CH_NUL;
    scan_phase         = SCAN_LINE_START;
    fixed_line         = 1'b0;
    sep_consumed       = 1'b0;
    before_first_field = 1'b1;

    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.text_byte    <= CH_NUL;
    in_chan.end_of_input <= 1'b0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.data        <= CH_NUL;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, tab separator from reset
    add_row(ROW_GIVEN,     "a",      1'b0, res_of("a", 1'b1, 1'b0, 1'b0));
    add_row(ROW_GIVEN,     CH_TAB,   1'b0, res_of(CH_NUL, 1'b0, 1'b1, 1'b0));
    add_row(ROW_PREDICTED, CH_TAB,   1'b0, '0);  // empty field between tabs
    // trailing separator gives one more empty field with the record end
    add_row(ROW_GIVEN,     CH_LF,    1'b0, res_of(CH_NUL, 1'b0, 1'b1, 1'b1));
    // end of input at line start: nothing
    add_row(ROW_NO_RESULT, 8'hff,    1'b1, '0);
    // zero after leading blanks: still nothing
    add_row(ROW_NO_RESULT, CH_SPACE, 1'b0, '0);
    add_row(ROW_NO_RESULT, CH_SPACE, 1'b0, '0);
    add_row(ROW_NO_RESULT, CH_NUL,   1'b0, '0);
    // blank mode line with punctuation gaps
    add_row(ROW_NO_RESULT, CH_SPACE, 1'b0, '0);
    add_row(ROW_PREDICTED, "x",      1'b0, '0);
    add_row(ROW_PREDICTED, CH_COMMA, 1'b0, '0);
    add_row(ROW_PREDICTED, CH_SEMI,  1'b0, '0);
    add_row(ROW_NO_RESULT, CH_SPACE, 1'b0, '0);
    add_row(ROW_GIVEN,     8'hff,    1'b0, res_of(8'hff, 1'b1, 1'b0, 1'b0));
    // lone carriage return, then more text
    add_row(ROW_PREDICTED, CH_CR,    1'b0, '0);
    add_row(ROW_PREDICTED, "y",      1'b0, '0);
    add_row(ROW_PREDICTED, CH_CR,    1'b0, '0);
    add_row(ROW_GIVEN,     CH_LF,    1'b0, res_of(CH_NUL, 1'b0, 1'b0, 1'b1));
    // empty line: one empty field
    add_row(ROW_GIVEN,     CH_LF,    1'b0, res_of(CH_NUL, 1'b0, 1'b1, 1'b1));
    add_row(ROW_PREDICTED, 8'h01,    1'b0, '0);
    add_row(ROW_GIVEN,     "q",      1'b1, res_of(CH_NUL, 1'b0, 1'b1, 1'b1));
    // space as fixed separator
    add_row(ROW_SEPARATOR, CH_SPACE, 1'b0, '0);
    add_row(ROW_PREDICTED, "a",      1'b0, '0);
    add_row(ROW_PREDICTED, CH_SPACE, 1'b0, '0);
    add_row(ROW_PREDICTED, CH_SPACE, 1'b0, '0);
    add_row(ROW_PREDICTED, "b",      1'b1, '0);
    // zero separator forces blank mode
    add_row(ROW_SEPARATOR, CH_NUL,   1'b0, '0);
    add_row(ROW_PREDICTED, "a",      1'b0, '0);
    add_row(ROW_PREDICTED, CH_TAB,   1'b0, '0);
    add_row(ROW_PREDICTED, CH_NUL,   1'b0, '0);
    // top separator value
    add_row(ROW_SEPARATOR, 8'hff,    1'b0, '0);
    add_row(ROW_PREDICTED, "a",      1'b0, '0);
    add_row(ROW_PREDICTED, 8'hff,    1'b0, '0);
    add_row(ROW_PREDICTED, CH_NUL,   1'b1, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SEPARATOR)
        write_separator(dir_rows[i].text);
      else
        push_text(dir_rows[i].text, dir_rows[i].eoi, dir_rows[i].kind, dir_rows[i].given);
    end

    // random phases, each with its own separator, extremes first
    seps[0] = SEP_RESET;
    seps[1] = CH_NUL;
    seps[2] = 8'hff;
    seps[3] = CH_SPACE;
    seps[4] = CH_COMMA;
    seps[5] = CH_SEMI;
    for (int p = 0; accepted_bytes < 1030; p++) begin
      sep_pick = (p < 6) ? seps[p] : char_t'($urandom_range(255));
      steady = 1'b0;
      write_separator(sep_pick);
      // one phase runs with no stalls on either side
      steady = (p == 3);
      phase_start = accepted_bytes;
      while (accepted_bytes - phase_start < 100)
        send_line();
    end
    steady = 1'b0;
    in_chan.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (expected_fields_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
